// ----- design/ppaf_pkg.sv -----
// Shared types, constants and helper functions for the point-pair angle feature core.
// No dependencies; every other design file except ppaf_checker imports this package.
package ppaf_pkg;

  localparam int ValW      = 31;  // scaled operand width, signed
  localparam int WideW     = 70;  // widest exact intermediate (w.n2)
  localparam int SqW       = 62;  // sum of three squares of scaled operands
  localparam int RootW     = SqW / 2;
  localparam int SqrtSteps = RootW;
  localparam int CordW     = 34;  // CORDIC datapath, covers the gain of the rotations
  localparam int CordInW   = ValW + 1;
  localparam int AccW      = 27;  // angle accumulator in 2^-16 degree
  localparam int CordSteps = 23;
  localparam int AngW      = 17;
  localparam int ShW       = 6;
  localparam int FitBits   = 30;  // operands must lie in [-2^30, 2^30)
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic signed [AccW-1:0] Deg180   = AccW'(11796480);
  localparam logic signed [AccW-1:0] Deg90    = AccW'(5898240);
  localparam logic signed [AngW-1:0] AngleMax = AngW'(46080);

  typedef struct packed {
    logic signed [ValW-1:0] b0;
    logic signed [ValW-1:0] b1;
    logic signed [ValW-1:0] b2;
    logic signed [ValW-1:0] bb;
    logic signed [ValW-1:0] a0;
    logic signed [ValW-1:0] a1;
    logic signed [ValW-1:0] a2;
    logic signed [ValW-1:0] ab;
    logic signed [ValW-1:0] gy;
    logic signed [ValW-1:0] gx;
    logic                   degen;
  } ppaf_ops_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ppaf_qstat_t;

  function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AccW-1:0] r;
    case (idx)
      5'd0:  r = AccW'(2949120);
      5'd1:  r = AccW'(1740967);
      5'd2:  r = AccW'(919879);
      5'd3:  r = AccW'(466945);
      5'd4:  r = AccW'(234379);
      5'd5:  r = AccW'(117304);
      5'd6:  r = AccW'(58666);
      5'd7:  r = AccW'(29335);
      5'd8:  r = AccW'(14668);
      5'd9:  r = AccW'(7334);
      5'd10: r = AccW'(3667);
      5'd11: r = AccW'(1833);
      5'd12: r = AccW'(917);
      5'd13: r = AccW'(458);
      5'd14: r = AccW'(229);
      5'd15: r = AccW'(115);
      5'd16: r = AccW'(57);
      5'd17: r = AccW'(29);
      5'd18: r = AccW'(14);
      5'd19: r = AccW'(7);
      5'd20: r = AccW'(4);
      5'd21: r = AccW'(2);
      5'd22: r = AccW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Smallest right shift that brings all four values into the operand range.
  // A bit that differs from the one above it marks how wide the value is.
  function automatic logic [ShW-1:0] fit_shift(input logic signed [WideW-1:0] a,
                                               input logic signed [WideW-1:0] b,
                                               input logic signed [WideW-1:0] c,
                                               input logic signed [WideW-1:0] e);
    logic [WideW-1:0] m;
    logic [6:0]       p;
    logic             found;
    m = (a ^ (a >>> 1)) | (b ^ (b >>> 1)) | (c ^ (c >>> 1)) | (e ^ (e >>> 1));
    p = '0;
    found = 1'b0;
    for (int k = 0; k < WideW; k++) begin
      if (m[k]) begin
        p = 7'(k);
        found = 1'b1;
      end
    end
    if (found && (p > 7'(FitBits - 1))) begin
      return ShW'(p - 7'(FitBits - 1));
    end
    return '0;
  endfunction

  function automatic logic signed [ValW-1:0] shr(input logic signed [WideW-1:0] x,
                                                 input logic [ShW-1:0] s);
    logic signed [WideW-1:0] t;
    t = x >>> s;
    return t[ValW-1:0];
  endfunction

endpackage

// ----- design/ppaf_front.sv -----
// Front part: takes input items, forms the exact vector products and scales operands.
// Depends on ppaf_pkg; feeds ppaf_queue.
module ppaf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  first_px_i,
  input  logic signed [15:0]  first_py_i,
  input  logic signed [15:0]  first_pz_i,
  input  logic signed [15:0]  first_nx_i,
  input  logic signed [15:0]  first_ny_i,
  input  logic signed [15:0]  first_nz_i,
  input  logic signed [15:0]  second_px_i,
  input  logic signed [15:0]  second_py_i,
  input  logic signed [15:0]  second_pz_i,
  input  logic signed [15:0]  second_nx_i,
  input  logic signed [15:0]  second_ny_i,
  input  logic signed [15:0]  second_nz_i,
  input  ppaf_pkg::ppaf_qstat_t qstat_i,
  output logic                push_o,
  output ppaf_pkg::ppaf_ops_t ops_o
);
  import ppaf_pkg::*;

  logic       fen;
  logic [5:0] vld_q;

  // stage 1
  logic signed [16:0] d_q [3];
  logic signed [15:0] u_q [3];
  logic signed [15:0] m_q [3];
  // stage 2
  logic signed [33:0] v_q [3];
  logic signed [15:0] m2_q [3];
  logic signed [34:0] ud_q, aa_q;
  logic signed [32:0] bb_q;
  logic signed [33:0] cc_q;
  // stage 3
  logic signed [33:0] v3_q [3];
  logic signed [51:0] c3_q [3];
  logic signed [51:0] vn3_q;
  logic signed [34:0] ud3_q;
  logic signed [33:0] cc3_q;
  logic signed [53:0] h_q, l_q;
  logic               dg3_q;
  // stage 4
  logic signed [33:0] v4_q [3];
  logic signed [51:0] c4_q [3];
  logic signed [51:0] vn4_q;
  logic signed [34:0] ud4_q;
  logic signed [33:0] cc4_q;
  logic signed [WideW-1:0] w_q;
  logic               dg4_q;
  // stage 5
  logic signed [33:0] v5_q [3];
  logic signed [51:0] c5_q [3];
  logic signed [51:0] vn5_q;
  logic signed [34:0] ud5_q;
  logic signed [33:0] cc5_q;
  logic signed [WideW-1:0] w5_q;
  logic               dg5_q;
  logic [ShW-1:0]     sb_q, sa_q, sg_q;
  // stage 6
  ppaf_ops_t          ops_q;

  // stage 2 products
  logic signed [32:0] pv [6];
  logic signed [32:0] pd [3], pa [3], pb [3], pc [3];
  logic signed [33:0] v_d [3];
  logic signed [34:0] ud_d, aa_d;
  logic signed [32:0] bb_d;
  logic signed [33:0] cc_d;
  // stage 3 products
  logic signed [49:0] pm [6];
  logic signed [49:0] pn [3];
  logic signed [51:0] c_d [3];
  logic signed [51:0] vn_d;
  logic signed [16:0] bh;
  logic signed [17:0] dh;
  logic signed [17:0] bl, dl;
  logic signed [51:0] ph0, ph1;
  logic signed [52:0] pl0, pl1;
  logic signed [53:0] h_d, l_d;
  logic               dg_d;

  // The front stalls only when its last stage holds an item the queue cannot take.
  assign fen        = !vld_q[5] || !qstat_i.full;
  assign in_ready_o = fen;
  assign push_o     = vld_q[5] && !qstat_i.full;
  assign ops_o      = ops_q;

  always_comb begin
    pv[0] = d_q[1] * u_q[2];
    pv[1] = d_q[2] * u_q[1];
    pv[2] = d_q[2] * u_q[0];
    pv[3] = d_q[0] * u_q[2];
    pv[4] = d_q[0] * u_q[1];
    pv[5] = d_q[1] * u_q[0];
    v_d[0] = pv[0] - pv[1];
    v_d[1] = pv[2] - pv[3];
    v_d[2] = pv[4] - pv[5];
    for (int k = 0; k < 3; k++) begin
      pd[k] = u_q[k] * d_q[k];
      pa[k] = d_q[k] * m_q[k];
      pb[k] = u_q[k] * u_q[k];
      pc[k] = u_q[k] * m_q[k];
    end
    ud_d = pd[0] + pd[1] + pd[2];
    aa_d = pa[0] + pa[1] + pa[2];
    bb_d = pb[0] + pb[1] + pb[2];
    cc_d = pc[0] + pc[1] + pc[2];
  end

  always_comb begin
    pm[0] = v_q[1] * m2_q[2];
    pm[1] = v_q[2] * m2_q[1];
    pm[2] = v_q[2] * m2_q[0];
    pm[3] = v_q[0] * m2_q[2];
    pm[4] = v_q[0] * m2_q[1];
    pm[5] = v_q[1] * m2_q[0];
    c_d[0] = pm[0] - pm[1];
    c_d[1] = pm[2] - pm[3];
    c_d[2] = pm[4] - pm[5];
    for (int k = 0; k < 3; k++) begin
      pn[k] = v_q[k] * m2_q[k];
    end
    vn_d = pn[0] + pn[1] + pn[2];
    // w.n2 = A*B - C*(u.d), with B and u.d split at bit 17 to keep multipliers narrow.
    bh  = $signed({1'b0, bb_q[32:17]});
    bl  = $signed({1'b0, bb_q[16:0]});
    dh  = ud_q[34:17];
    dl  = $signed({1'b0, ud_q[16:0]});
    ph0 = aa_q * bh;
    ph1 = cc_q * dh;
    pl0 = aa_q * bl;
    pl1 = cc_q * dl;
    h_d = ph0 - ph1;
    l_d = pl0 - pl1;
    dg_d = ((v_q[0] == 0) && (v_q[1] == 0) && (v_q[2] == 0)) ||
           ((m2_q[0] == 0) && (m2_q[1] == 0) && (m2_q[2] == 0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (fen) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      d_q[0] <= 17'(second_px_i) - 17'(first_px_i);
      d_q[1] <= 17'(second_py_i) - 17'(first_py_i);
      d_q[2] <= 17'(second_pz_i) - 17'(first_pz_i);
      u_q[0] <= first_nx_i;
      u_q[1] <= first_ny_i;
      u_q[2] <= first_nz_i;
      m_q[0] <= second_nx_i;
      m_q[1] <= second_ny_i;
      m_q[2] <= second_nz_i;

      v_q   <= v_d;
      m2_q  <= m_q;
      ud_q  <= ud_d;
      aa_q  <= aa_d;
      bb_q  <= bb_d;
      cc_q  <= cc_d;

      v3_q  <= v_q;
      c3_q  <= c_d;
      vn3_q <= vn_d;
      ud3_q <= ud_q;
      cc3_q <= cc_q;
      h_q   <= h_d;
      l_q   <= l_d;
      dg3_q <= dg_d;

      v4_q  <= v3_q;
      c4_q  <= c3_q;
      vn4_q <= vn3_q;
      ud4_q <= ud3_q;
      cc4_q <= cc3_q;
      w_q   <= (WideW'(h_q) <<< 17) + WideW'(l_q);
      dg4_q <= dg3_q;

      v5_q  <= v4_q;
      c5_q  <= c4_q;
      vn5_q <= vn4_q;
      ud5_q <= ud4_q;
      cc5_q <= cc4_q;
      w5_q  <= w_q;
      dg5_q <= dg4_q;
      sb_q  <= fit_shift(WideW'(v4_q[0]), WideW'(v4_q[1]), WideW'(v4_q[2]), WideW'(ud4_q));
      sa_q  <= fit_shift(WideW'(c4_q[0]), WideW'(c4_q[1]), WideW'(c4_q[2]), WideW'(vn4_q));
      sg_q  <= fit_shift(w_q, WideW'(cc4_q), WideW'(cc4_q), WideW'(cc4_q));

      ops_q.b0    <= shr(WideW'(v5_q[0]), sb_q);
      ops_q.b1    <= shr(WideW'(v5_q[1]), sb_q);
      ops_q.b2    <= shr(WideW'(v5_q[2]), sb_q);
      ops_q.bb    <= shr(WideW'(ud5_q), sb_q);
      ops_q.a0    <= shr(WideW'(c5_q[0]), sa_q);
      ops_q.a1    <= shr(WideW'(c5_q[1]), sa_q);
      ops_q.a2    <= shr(WideW'(c5_q[2]), sa_q);
      ops_q.ab    <= shr(WideW'(vn5_q), sa_q);
      ops_q.gy    <= shr(w5_q, sg_q);
      ops_q.gx    <= shr(WideW'(cc5_q), sg_q);
      ops_q.degen <= dg5_q;
    end
  end

endmodule

// ----- design/ppaf_queue.sv -----
// Short item queue between the front and back parts.
// Depends on ppaf_pkg for the operand bundle and status types.
module ppaf_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ppaf_pkg::ppaf_ops_t   data_i,
  input  logic                  pop_i,
  output ppaf_pkg::ppaf_ops_t   data_o,
  output ppaf_pkg::ppaf_qstat_t stat_o
);
  import ppaf_pkg::*;

  ppaf_ops_t         mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q;

  assign data_o       = mem_q[rptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (FifoAw+1)'(FifoDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- design/ppaf_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on ppaf_pkg; used by ppaf_back.
module ppaf_isqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ppaf_pkg::SqW-1:0]  n_i,
  output logic [ppaf_pkg::RootW-1:0] root_o
);
  import ppaf_pkg::*;

  logic [SqW-1:0]   n_q    [SqrtSteps];
  logic [RootW+1:0] rem_q  [SqrtSteps];
  logic [RootW-1:0] root_q [SqrtSteps];

  logic [SqW-1:0]   n_d    [SqrtSteps];
  logic [RootW+1:0] rem_d  [SqrtSteps];
  logic [RootW-1:0] root_d [SqrtSteps];

  assign root_o = root_q[SqrtSteps-1];

  always_comb begin
    logic [SqW-1:0]   n_in;
    logic [RootW+1:0] rem_in;
    logic [RootW-1:0] root_in;
    logic [RootW+3:0] r2, trial;
    for (int k = 0; k < SqrtSteps; k++) begin
      if (k == 0) begin
        n_in    = n_i;
        rem_in  = '0;
        root_in = '0;
      end else begin
        n_in    = n_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
      end
      // Bring down the next pair of bits, most significant first.
      r2    = {rem_in, n_in[2*(SqrtSteps-1-k)+1 -: 2]};
      trial = (RootW+4)'({root_in, 2'b01});
      n_d[k] = n_in;
      if (r2 >= trial) begin
        rem_d[k]  = (RootW+2)'(r2 - trial);
        root_d[k] = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d[k]  = (RootW+2)'(r2);
        root_d[k] = {root_in[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

endmodule

// ----- design/ppaf_cordic.sv -----
// Pipelined CORDIC vectoring unit: atan2(y, x) in degrees Q8.8, rounded and clamped.
// Depends on ppaf_pkg for the arctangent table; used by ppaf_back.
module ppaf_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ppaf_pkg::CordInW-1:0] y_i,
  input  logic signed [ppaf_pkg::CordInW-1:0] x_i,
  output logic signed [ppaf_pkg::AngW-1:0]  ang_o
);
  import ppaf_pkg::*;

  logic signed [CordW-1:0] x_q   [CordSteps+1];
  logic signed [CordW-1:0] y_q   [CordSteps+1];
  logic signed [AccW-1:0]  acc_q [CordSteps+1];
  logic                    hold_q [CordSteps+1];

  logic signed [CordW-1:0] x0, y0;
  logic signed [AccW-1:0]  acc0;
  logic                    hold0;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-9:0]  q;

  // Axis cases settle the angle at once and hold it through the iterations.
  always_comb begin
    x0    = CordW'(x_i);
    y0    = CordW'(y_i);
    acc0  = '0;
    hold0 = 1'b0;
    if (y_i == 0) begin
      hold0 = 1'b1;
      acc0  = (x_i < 0) ? Deg180 : '0;
    end else if (x_i == 0) begin
      hold0 = 1'b1;
      acc0  = (y_i > 0) ? Deg90 : -Deg90;
    end else if (x_i < 0) begin
      acc0 = (y_i > 0) ? Deg180 : -Deg180;
      x0   = -CordW'(x_i);
      y0   = -CordW'(y_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      acc_q[0]  <= acc0;
      hold_q[0] <= hold0;
      for (int i = 0; i < CordSteps; i++) begin
        hold_q[i+1] <= hold_q[i];
        if (hold_q[i]) begin
          x_q[i+1]   <= x_q[i];
          y_q[i+1]   <= y_q[i];
          acc_q[i+1] <= acc_q[i];
        end else if (y_q[i] > 0) begin
          x_q[i+1]   <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1]   <= y_q[i] - (x_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] + atan_entry(5'(i));
        end else begin
          x_q[i+1]   <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1]   <= y_q[i] + (x_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] - atan_entry(5'(i));
        end
      end
    end
  end

  always_comb begin
    rnd = acc_q[CordSteps] + AccW'(128);
    q   = rnd[AccW-1:8];
    if (q > (AccW-8)'(AngleMax)) begin
      ang_o = AngleMax;
    end else if (q < -(AccW-8)'(AngleMax)) begin
      ang_o = -AngleMax;
    end else begin
      ang_o = q[AngW-1:0];
    end
  end

endmodule

// ----- design/ppaf_back.sv -----
// Back part: magnitudes, angle evaluation and the output register.
// Depends on ppaf_pkg, ppaf_isqrt and ppaf_cordic; reads items from ppaf_queue.
module ppaf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppaf_pkg::ppaf_ops_t   ops_i,
  input  ppaf_pkg::ppaf_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           alpha_deg_o,
  output logic [15:0]           beta_deg_o,
  output logic signed [16:0]    gamma_deg_o,
  output logic                  degenerate_o
);
  import ppaf_pkg::*;

  localparam int MagLvl = 2 + SqrtSteps;         // level of the square-root results
  localparam int AngLvl = MagLvl + CordSteps + 1; // level of the angle results
  localparam int OutLvl = AngLvl + 1;

  logic              en;
  logic [OutLvl-1:0] vld_q;

  logic [SqW-1:0]  sqb_q [3], sqa_q [3];
  logic [SqW-1:0]  sumb_q, suma_q;
  logic [SqW-1:0]  sqb_d [3], sqa_d [3];
  logic signed [SqW-1:0] pb [3], pa [3];

  logic signed [ValW-1:0] bx_q [MagLvl], ax_q [MagLvl], gy_q [MagLvl], gx_q [MagLvl];
  logic                   dg_q [AngLvl];

  logic [RootW-1:0]       rootb, roota;
  logic signed [AngW-1:0] angb, anga, angg;

  logic [15:0]            alpha_q, beta_q;
  logic signed [AngW-1:0] gamma_q;
  logic                   degen_q;

  // One enable moves the whole back pipeline; it stalls only when a result waits.
  assign en    = !vld_q[OutLvl-1] || out_ready_i;
  assign pop_o = en && !qstat_i.empty;

  assign out_valid_o  = vld_q[OutLvl-1];
  assign alpha_deg_o  = alpha_q;
  assign beta_deg_o   = beta_q;
  assign gamma_deg_o  = gamma_q;
  assign degenerate_o = degen_q;

  always_comb begin
    pb[0] = ops_i.b0 * ops_i.b0;
    pb[1] = ops_i.b1 * ops_i.b1;
    pb[2] = ops_i.b2 * ops_i.b2;
    pa[0] = ops_i.a0 * ops_i.a0;
    pa[1] = ops_i.a1 * ops_i.a1;
    pa[2] = ops_i.a2 * ops_i.a2;
    for (int k = 0; k < 3; k++) begin
      sqb_d[k] = pb[k];
      sqa_d[k] = pa[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[OutLvl-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqb_q  <= sqb_d;
      sqa_q  <= sqa_d;
      sumb_q <= sqb_q[0] + sqb_q[1] + sqb_q[2];
      suma_q <= sqa_q[0] + sqa_q[1] + sqa_q[2];
      bx_q[0] <= ops_i.bb;
      ax_q[0] <= ops_i.ab;
      gy_q[0] <= ops_i.gy;
      gx_q[0] <= ops_i.gx;
      dg_q[0] <= ops_i.degen;
      for (int k = 1; k < MagLvl; k++) begin
        bx_q[k] <= bx_q[k-1];
        ax_q[k] <= ax_q[k-1];
        gy_q[k] <= gy_q[k-1];
        gx_q[k] <= gx_q[k-1];
      end
      for (int k = 1; k < AngLvl; k++) begin
        dg_q[k] <= dg_q[k-1];
      end
      degen_q <= dg_q[AngLvl-1];
      if (dg_q[AngLvl-1]) begin
        alpha_q <= '0;
        beta_q  <= '0;
        gamma_q <= '0;
      end else begin
        // The magnitude-side angles cannot be negative; a small rounding dip reads as zero.
        alpha_q <= (anga < 0) ? '0 : anga[15:0];
        beta_q  <= (angb < 0) ? '0 : angb[15:0];
        gamma_q <= angg;
      end
    end
  end

  ppaf_isqrt u_sqrt_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (sumb_q),
    .root_o (rootb)
  );

  ppaf_isqrt u_sqrt_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (suma_q),
    .root_o (roota)
  );

  ppaf_cordic u_cordic_b (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ($signed({1'b0, rootb})),
    .x_i   (CordInW'(bx_q[MagLvl-1])),
    .ang_o (angb)
  );

  ppaf_cordic u_cordic_a (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ($signed({1'b0, roota})),
    .x_i   (CordInW'(ax_q[MagLvl-1])),
    .ang_o (anga)
  );

  ppaf_cordic u_cordic_g (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CordInW'(gy_q[MagLvl-1])),
    .x_i   (CordInW'(gx_q[MagLvl-1])),
    .ang_o (angg)
  );

endmodule

// ----- design/point_pair_angle_feature_core.sv -----
// Point-pair angle feature core: alpha, beta and gamma of two oriented points.
// Takes one item per cycle while the output is taken and nothing stalls.
// Results pass through the two 31-stage square-root pipelines and the 24-stage CORDIC units.
// A four-item queue lets the front keep accepting while the back waits on the output.
// Reset (rst_ni low, asynchronous) clears all valid bits and the queue; no clearing pass.
module point_pair_angle_feature_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] first_px_i,
  input  logic signed [15:0] first_py_i,
  input  logic signed [15:0] first_pz_i,
  input  logic signed [15:0] first_nx_i,
  input  logic signed [15:0] first_ny_i,
  input  logic signed [15:0] first_nz_i,
  input  logic signed [15:0] second_px_i,
  input  logic signed [15:0] second_py_i,
  input  logic signed [15:0] second_pz_i,
  input  logic signed [15:0] second_nx_i,
  input  logic signed [15:0] second_ny_i,
  input  logic signed [15:0] second_nz_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        alpha_deg_o,
  output logic [15:0]        beta_deg_o,
  output logic signed [16:0] gamma_deg_o,
  output logic               degenerate_o
);
  import ppaf_pkg::*;

  logic        push, pop;
  ppaf_ops_t   ops_in, ops_out;
  ppaf_qstat_t qstat;

  ppaf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .first_px_i  (first_px_i),
    .first_py_i  (first_py_i),
    .first_pz_i  (first_pz_i),
    .first_nx_i  (first_nx_i),
    .first_ny_i  (first_ny_i),
    .first_nz_i  (first_nz_i),
    .second_px_i (second_px_i),
    .second_py_i (second_py_i),
    .second_pz_i (second_pz_i),
    .second_nx_i (second_nx_i),
    .second_ny_i (second_ny_i),
    .second_nz_i (second_nz_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .ops_o       (ops_in)
  );

  ppaf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (ops_in),
    .pop_i  (pop),
    .data_o (ops_out),
    .stat_o (qstat)
  );

  ppaf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ops_i        (ops_out),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .alpha_deg_o  (alpha_deg_o),
    .beta_deg_o   (beta_deg_o),
    .gamma_deg_o  (gamma_deg_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ----- design/ppaf_checker.sv -----
// Port-level checks for the point-pair angle feature core, bound to the top level.
// Depends only on the top level's ports.
module ppaf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        alpha_deg_o,
  input logic [15:0]        beta_deg_o,
  input logic signed [16:0] gamma_deg_o,
  input logic               degenerate_o
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alpha_deg_o) &&
    $stable(beta_deg_o) && $stable(gamma_deg_o) && $stable(degenerate_o))
    else $error("result changed while stalled");

  // A degenerate item reports all three angles as zero.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> alpha_deg_o == 16'd0 && beta_deg_o == 16'd0 &&
    gamma_deg_o == 17'sd0)
    else $error("degenerate item with non-zero angle");

  a_ab_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alpha_deg_o <= 16'd46080 && beta_deg_o <= 16'd46080)
    else $error("alpha or beta beyond 180 degrees");

  a_g_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gamma_deg_o <= 17'sd46080 && gamma_deg_o >= -17'sd46080)
    else $error("gamma beyond 180 degrees");

endmodule

bind point_pair_angle_feature_core ppaf_checker u_ppaf_checker (.*);

// ----- tb/sv/point_pair_angle_feature_checker.sv -----
// Checker for the point-pair angle feature core: watches both channels, predicts each result
// from the accepted point pair and compares it field by field. Depends on nothing but the ports.
module point_pair_angle_feature_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [11:0][15:0] pair_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [15:0]       alpha_deg_i,
  input  logic [15:0]       beta_deg_i,
  input  logic signed [16:0] gamma_deg_i,
  input  logic              degenerate_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Deg180Q16 = 11796480;
  localparam longint Deg90Q16  = 5898240;
  localparam longint FitLimit  = 64'sd1073741824;
  localparam longint AngleLim  = 46080;

  typedef struct packed {
    logic [15:0]        alpha;
    logic [15:0]        beta;
    logic signed [16:0] gamma;
    logic               degen;
  } angles_t;

  angles_t angle_queue[$];

  const longint atan_steps[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                                    29, 14, 7, 4, 2, 1};

  // Smallest shift that brings every value into [-2^30, 2^30).
  function automatic int scale_shift(input longint vals[4], input int n);
    bool_loop: for (int s = 0; s < 63; s++) begin
      automatic bit ok = 1'b1;
      for (int i = 0; i < n; i++) begin
        if ((vals[i] >>> s) < -FitLimit || (vals[i] >>> s) >= FitLimit) ok = 1'b0;
      end
      if (ok) return s;
    end
    return 63;
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint atan2_deg(input longint y, input longint x);
    longint acc, xs, ys, q;
    acc = 0;
    if (y == 0) return (x < 0) ? AngleLim : 0;
    if (x == 0) begin
      acc = (y > 0) ? Deg90Q16 : -Deg90Q16;
    end else begin
      if (x < 0) begin
        acc = (y >= 0) ? Deg180Q16 : -Deg180Q16;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 23; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          acc += atan_steps[i];
        end else begin
          x = x - ys;
          y = y + xs;
          acc -= atan_steps[i];
        end
      end
    end
    q = (acc + 128) >>> 8;
    if (q > AngleLim) q = AngleLim;
    if (q < -AngleLim) q = -AngleLim;
    return q;
  endfunction

  function automatic longint scaled_atan2(input longint y, input longint x);
    longint vals[4];
    int s;
    vals = '{y, x, 0, 0};
    s = scale_shift(vals, 2);
    return atan2_deg(y >>> s, x >>> s);
  endfunction

  // Angle whose sine side is the length of a and cosine side is b.
  function automatic longint length_angle(input longint a0, input longint a1, input longint a2,
                                          input longint b);
    longint vals[4];
    longint c0, c1, c2, r;
    int s;
    vals = '{a0, a1, a2, b};
    s = scale_shift(vals, 4);
    c0 = a0 >>> s;
    c1 = a1 >>> s;
    c2 = a2 >>> s;
    r = root_floor(longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2));
    r = atan2_deg(r, b >>> s);
    return (r < 0) ? 0 : r;
  endfunction

  function automatic angles_t pair_angles(input logic [11:0][15:0] p);
    longint d0, d1, d2, u0, u1, u2, m0, m1, m2, v0, v1, v2, c0, c1, c2;
    longint ud, vn, a, b, c, bh, bl, dh, dl, h, l, top, rem;
    longint alpha, beta, gamma;
    angles_t r;
    d0 = longint'($signed(p[6])) - longint'($signed(p[0]));
    d1 = longint'($signed(p[7])) - longint'($signed(p[1]));
    d2 = longint'($signed(p[8])) - longint'($signed(p[2]));
    u0 = longint'($signed(p[3]));
    u1 = longint'($signed(p[4]));
    u2 = longint'($signed(p[5]));
    m0 = longint'($signed(p[9]));
    m1 = longint'($signed(p[10]));
    m2 = longint'($signed(p[11]));
    v0 = d1 * u2 - d2 * u1;
    v1 = d2 * u0 - d0 * u2;
    v2 = d0 * u1 - d1 * u0;
    alpha = 0;
    beta = 0;
    gamma = 0;
    r.degen = (v0 == 0 && v1 == 0 && v2 == 0) || (m0 == 0 && m1 == 0 && m2 == 0);
    if (!r.degen) begin
      ud = u0 * d0 + u1 * d1 + u2 * d2;
      beta = length_angle(v0, v1, v2, ud);
      c0 = v1 * m2 - v2 * m1;
      c1 = v2 * m0 - v0 * m2;
      c2 = v0 * m1 - v1 * m0;
      vn = v0 * m0 + v1 * m1 + v2 * m2;
      alpha = length_angle(c0, c1, c2, vn);
      // w.n2 is too wide for one word, so it is built from a high part and a remainder.
      a = d0 * m0 + d1 * m1 + d2 * m2;
      b = u0 * u0 + u1 * u1 + u2 * u2;
      c = u0 * m0 + u1 * m1 + u2 * m2;
      bh = b >>> 17;
      bl = b & 64'h1FFFF;
      dh = ud >>> 17;
      dl = ud & 64'h1FFFF;
      h = a * bh - c * dh;
      l = a * bl - c * dl;
      top = h + (l >>> 17);
      rem = l & 64'h1FFFF;
      if (top >= -(64'sd1 << 44) && top < (64'sd1 << 44))
        gamma = scaled_atan2(top * 131072 + rem, c);
      else
        gamma = scaled_atan2(top, c >>> 17);
    end
    r.alpha = alpha[15:0];
    r.beta = beta[15:0];
    r.gamma = gamma[16:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = angle_queue.size();

  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) angle_queue.push_back(pair_angles(pair_i));
      if (out_valid_i && out_ready_i) begin
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = angle_queue.pop_front();
          if (degenerate_i !== want.degen) report_mismatch("degenerate", degenerate_i, want.degen);
          if (alpha_deg_i !== want.alpha) report_mismatch("alpha_deg", alpha_deg_i, want.alpha);
          if (beta_deg_i !== want.beta) report_mismatch("beta_deg", beta_deg_i, want.beta);
          if (gamma_deg_i !== want.gamma) report_mismatch("gamma_deg", gamma_deg_i, want.gamma);
        end
      end
    end
  end

endmodule

// ----- tb/sv/point_pair_angle_feature_core_tb.sv -----
// Top of the point-pair angle feature core testbench: clock, reset, stimulus and verdict.
// Depends on point_pair_angle_feature_core and point_pair_angle_feature_checker.
module point_pair_angle_feature_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1850;
  localparam int IdleLimit   = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [11:0][15:0] pair = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       alpha_deg, beta_deg;
  logic signed [16:0] gamma_deg;
  logic              degenerate;
  int                fail_count, pending, idle_cycles;
  logic [11:0][15:0] directed[$];

  always #5 clk = ~clk;

  point_pair_angle_feature_core i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_px_i(pair[0]), .first_py_i(pair[1]), .first_pz_i(pair[2]),
    .first_nx_i(pair[3]), .first_ny_i(pair[4]), .first_nz_i(pair[5]),
    .second_px_i(pair[6]), .second_py_i(pair[7]), .second_pz_i(pair[8]),
    .second_nx_i(pair[9]), .second_ny_i(pair[10]), .second_nz_i(pair[11]),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .alpha_deg_o(alpha_deg),
    .beta_deg_o(beta_deg), .gamma_deg_o(gamma_deg), .degenerate_o(degenerate)
  );

  point_pair_angle_feature_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pair_i(pair), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .alpha_deg_i(alpha_deg), .beta_deg_i(beta_deg), .gamma_deg_i(gamma_deg),
    .degenerate_i(degenerate), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [15:0] pick_coord(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8) - 4);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h8001;
          2: return 16'h7FFF;
          3: return 16'hFFFF;
          4: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [11:0][15:0] random_pair();
    logic [11:0][15:0] p;
    int style, k;
    style = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      if (style < 6) p[i] = pick_coord(0);
      else if (style < 8) p[i] = pick_coord(1);
      else p[i] = pick_coord($urandom_range(0, 2));
    end
    // Now and then the points coincide, the first normal is made parallel to the offset, or the second normal is zero.
    k = $urandom_range(0, 19);
    if (k == 0) begin
      for (int i = 0; i < 3; i++) p[6 + i] = p[i];
    end else if (k == 1) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = 16'($urandom_range(0, 200) - 100);
        p[6 + i] = 16'($urandom_range(0, 200) - 100);
        p[3 + i] = 16'(($signed(p[6 + i]) - $signed(p[i])) * 3);
      end
    end else if (k == 2) begin
      for (int i = 0; i < 3; i++) p[9 + i] = '0;
    end
    return p;
  endfunction

  task automatic add_directed(input int p1x, p1y, p1z, n1x, n1y, n1z,
                              input int p2x, p2y, p2z, n2x, n2y, n2z);
    directed.push_back({16'(n2z), 16'(n2y), 16'(n2x), 16'(p2z), 16'(p2y), 16'(p2x),
                        16'(n1z), 16'(n1y), 16'(n1x), 16'(p1z), 16'(p1y), 16'(p1x)});
  endtask

  // Receiver: keeps switching among four randomly chosen stall patterns on out_ready.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat (64) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 1) == 1);
          2: out_ready = ($urandom_range(0, 7) == 0);
          default: out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("point_pair_angle_feature_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int burst, sent;
    idle_cycles = 0;
    add_directed(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_directed(5, 5, 5, 1, 0, 0, 5, 5, 5, 0, 0, 1);             // points coincide
    add_directed(0, 0, 0, 0, 0, 0, 10, 0, 0, 0, 1, 0);            // zero first normal
    add_directed(0, 0, 0, 0, 1, 0, 10, 0, 0, 0, 0, 0);            // zero second normal
    add_directed(0, 0, 0, 2, 0, 0, 7, 0, 0, 0, 1, 0);             // normal along offset
    add_directed(0, 0, 0, 0, 1, 0, 10, 0, 0, 0, 0, 1);            // n2 along v
    add_directed(0, 0, 0, 0, 1, 0, 10, 0, 0, 0, 0, -1);
    add_directed(0, 0, 0, 0, 1, 0, 10, 0, 0, 0, 1, 0);            // n2 along u
    add_directed(0, 0, 0, 0, 1, 0, 10, 0, 0, 0, -1, 0);
    add_directed(0, 0, 0, 1, 1, 0, 10, 0, 0, 1, 0, 0);
    add_directed(0, 0, 0, -1, 1, 0, 10, 0, 0, -1, 0, 0);
    add_directed(-32768, -32768, -32768, 32767, -32768, 32767,
                 32767, 32767, 32767, -32768, 32767, -32768);
    add_directed(32767, 32767, 32767, -32768, -32768, -32768,
                 -32768, -32768, -32768, 32767, 32767, 32767);
    add_directed(-32768, 0, 32767, -32768, -32768, 1, 32767, -1, -32768, 32767, 1, -32768);
    add_directed(-32768, 32767, 0, 32767, 32767, 32767, 32767, -32768, 0, -32768, -32768, 1);
    add_directed(-1, -1, -1, -1, -1, -1, 0, 0, 0, 1, 1, 1);
    add_directed(1, 2, 3, -3, 2, -1, 4, 5, 6, 7, -8, 9);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    sent = 0;
    while (sent < directed.size() + RandomItems) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if (sent < directed.size()) pair = directed[sent];
        else pair = random_pair();
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        @(negedge clk);
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("point_pair_angle_feature_core_tb passed");
    end else begin
      $display("point_pair_angle_feature_core_tb failed");
    end
    $finish;
  end

endmodule
